FILE: rtl/kwmt_pkg.sv
`timescale 1ns / 1ps
// kwmt_pkg: shared types, field widths and compare helper for the k-way merge tree.
// No dependencies; imported by kwmt_ctrl, kwmt_dpath and k_way_merge_tournament.
package kwmt_pkg;

  localparam int WAYS_DEF   = 16;

  localparam int LANE_W     = 4;
  localparam int KEY_W      = 64;
  localparam int ROW_W      = 63;
  localparam int ACT_W      = 2;
  localparam int LIM_W      = 5;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 136;

  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(16);

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_START  = 2'd1,
    ACT_REFILL = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_KILL,
    ST_SRD,
    ST_SCMP,
    ST_LEAF,
    ST_RPL,
    ST_ROW,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;      // latch input payload
    logic load_leaf;    // write a lane head into its leaf
    logic kill;         // force lanes past the limit exhausted, arm seed counter
    logic seed_rd;      // read both children of the current pair
    logic seed_cmp;     // compare pair, write parent
    logic refill_leaf;  // write winner leaf, start path replay
    logic replay;       // one level of the path replay
    logic row_rd;       // fetch the root lane's row
    logic emit;         // load the output register
  } cmd_t;

  typedef struct packed {
    logic root_dead;
    logic seed_last;
    logic replay_last;
    logic out_free;
  } sts_t;

  // x beats y when x is live and y is exhausted or holds a larger key
  function automatic logic x_wins(input logic             x_dead,
                                  input logic [KEY_W-1:0] x_key,
                                  input logic             y_dead,
                                  input logic [KEY_W-1:0] y_key);
    return !x_dead && (y_dead || (x_key < y_key));
  endfunction

endpackage

FILE: rtl/kwmt_ctrl.sv
`timescale 1ns / 1ps
// kwmt_ctrl: sequencer for load, seed and replay of the merge tree.
// Depends on kwmt_pkg (state_e, action_e, cmd_t, sts_t).
module kwmt_ctrl import kwmt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ACT_W-1:0] in_action_i,
  output logic             in_ready_o,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  state_e state_q, state_d;
  action_e act;

  assign act = action_e'(in_action_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (act)
            ACT_LOAD:   state_d = ST_LOAD;
            ACT_START:  state_d = ST_KILL;
            ACT_REFILL: state_d = sts_i.root_dead ? ST_ROW : ST_LEAF;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_KILL: state_d = ST_SRD;
      ST_SRD:  state_d = ST_SCMP;
      ST_SCMP: state_d = sts_i.seed_last ? ST_ROW : ST_SRD;
      ST_LEAF: state_d = ST_RPL;
      ST_RPL:  state_d = sts_i.replay_last ? ST_ROW : ST_RPL;
      ST_ROW:  state_d = ST_EMIT;
      ST_EMIT: state_d = sts_i.out_free ? ST_IDLE : ST_EMIT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    in_ready_o        = (state_q == ST_IDLE);
    cmd_o.capture     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.load_leaf   = (state_q == ST_LOAD);
    cmd_o.kill        = (state_q == ST_KILL);
    cmd_o.seed_rd     = (state_q == ST_SRD);
    cmd_o.seed_cmp    = (state_q == ST_SCMP);
    cmd_o.refill_leaf = (state_q == ST_LEAF);
    cmd_o.replay      = (state_q == ST_RPL);
    cmd_o.row_rd      = (state_q == ST_ROW);
    cmd_o.emit        = (state_q == ST_EMIT) && sts_i.out_free;
  end

endmodule

FILE: rtl/kwmt_dpath.sv
`timescale 1ns / 1ps
// kwmt_dpath: node memory, exhausted flags, row store, compare unit and output register.
// Depends on kwmt_pkg; driven by kwmt_ctrl commands.
module kwmt_dpath import kwmt_pkg::*; #(
  parameter int WAYS = WAYS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [LIM_W-1:0]  lanes_in_use_i,
  input  logic [LANE_W-1:0] in_lane_i,
  input  logic [KEY_W-1:0]  in_key_i,
  input  logic [ROW_W-1:0]  in_row_i,
  input  logic              in_exh_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KEY_W-1:0]  out_key_o,
  output logic [ROW_W-1:0]  out_row_o,
  output logic [LANE_W-1:0] out_lane_o,
  output logic              out_done_o
);

  localparam int LW    = $clog2(WAYS);
  localparam int NODES = 2 * WAYS;
  localparam int NW    = $clog2(NODES);

  localparam logic [NW-1:0] LEAF_BASE = NW'(WAYS);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
  localparam logic [NW-1:0] SEED_END  = NW'(3);
  localparam logic [NW-1:0] ROOT      = NW'(1);
  localparam logic [NW-1:0] ONE       = NW'(1);
  localparam logic [NW-1:0] TWO       = NW'(2);

  // captured input payload
  logic [LANE_W-1:0] lane_q;
  logic [KEY_W-1:0]  key_q;
  logic [ROW_W-1:0]  row_q;
  logic              exh_q;

  // node store: node 1 is the root, node WAYS+i the leaf of lane i
  logic [KEY_W-1:0] nkey_mem  [NODES];
  logic [LW-1:0]    nlane_mem [NODES];
  logic [ROW_W-1:0] row_mem   [WAYS];
  logic [NODES-1:0] dead_q;

  logic [KEY_W-1:0] a_key_q, b_key_q;
  logic [LW-1:0]    a_lane_q, b_lane_q;
  logic [ROW_W-1:0] row_rd_q;

  logic [NW-1:0]    idx_q;
  logic [KEY_W-1:0] cand_key_q;
  logic [LW-1:0]    cand_lane_q;
  logic             cand_dead_q;
  logic [KEY_W-1:0] root_key_q;
  logic [LW-1:0]    root_lane_q;
  logic [LW-1:0]    winner_q;

  logic              out_valid_q;
  logic [KEY_W-1:0]  out_key_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [LANE_W-1:0] out_lane_q;
  logic              out_done_q;

  logic             load_ok;
  logic [NW-1:0]    load_node, win_node, parent, sib;
  logic             seed_x, rep_x;
  logic [KEY_W-1:0] seed_key, rep_key;
  logic [LW-1:0]    seed_lane, rep_lane;
  logic             seed_dead, rep_dead;

  logic             we;
  logic [NW-1:0]    waddr, raddr_a, raddr_b;
  logic [KEY_W-1:0] wkey;
  logic [LW-1:0]    wlane;
  logic             rd_en;

  assign load_ok   = int'(lane_q) < WAYS;
  assign load_node = LEAF_BASE + NW'(lane_q);
  assign win_node  = LEAF_BASE + NW'(winner_q);
  assign parent    = idx_q >> 1;
  assign sib       = idx_q ^ ONE;

  // seeding: odd right child challenges; ties and double-dead go to the left child
  assign seed_x    = x_wins(dead_q[idx_q], a_key_q, dead_q[idx_q - ONE], b_key_q);
  assign seed_key  = seed_x ? a_key_q  : b_key_q;
  assign seed_lane = seed_x ? a_lane_q : b_lane_q;
  assign seed_dead = seed_x ? dead_q[idx_q] : dead_q[idx_q - ONE];

  // replay: path node challenges; ties go to the sibling
  assign rep_x    = x_wins(cand_dead_q, cand_key_q, dead_q[sib], a_key_q);
  assign rep_key  = rep_x ? cand_key_q  : a_key_q;
  assign rep_lane = rep_x ? cand_lane_q : a_lane_q;
  assign rep_dead = rep_x ? cand_dead_q : dead_q[sib];

  always_comb begin
    we    = 1'b0;
    waddr = load_node;
    wkey  = key_q;
    wlane = LW'(lane_q);
    if (cmd_i.load_leaf && load_ok) begin
      we = 1'b1;
    end else if (cmd_i.refill_leaf && !exh_q) begin
      we    = 1'b1;
      waddr = win_node;
      wlane = winner_q;
    end else if (cmd_i.seed_cmp) begin
      we    = 1'b1;
      waddr = parent;
      wkey  = seed_key;
      wlane = seed_lane;
    end else if (cmd_i.replay) begin
      we    = 1'b1;
      waddr = parent;
      wkey  = rep_key;
      wlane = rep_lane;
    end
  end

  always_comb begin
    rd_en   = cmd_i.seed_rd || cmd_i.refill_leaf || cmd_i.replay;
    raddr_a = idx_q;
    raddr_b = idx_q - ONE;
    if (cmd_i.refill_leaf) begin
      raddr_a = win_node ^ ONE;
    end else if (cmd_i.replay) begin
      raddr_a = parent ^ ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      nkey_mem[waddr]  <= wkey;
      nlane_mem[waddr] <= wlane;
    end
    if (rd_en) begin
      a_key_q  <= nkey_mem[raddr_a];
      a_lane_q <= nlane_mem[raddr_a];
      b_key_q  <= nkey_mem[raddr_b];
      b_lane_q <= nlane_mem[raddr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_leaf && load_ok) begin
      row_mem[LW'(lane_q)] <= row_q;
    end else if (cmd_i.refill_leaf && !exh_q) begin
      row_mem[winner_q] <= row_q;
    end
    if (cmd_i.row_rd) begin
      row_rd_q <= row_mem[root_lane_q];
    end
  end

  // payload, candidate, root and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lane_q <= in_lane_i;
      key_q  <= in_key_i;
      row_q  <= in_row_i;
      exh_q  <= in_exh_i;
    end
    if (cmd_i.refill_leaf) begin
      cand_key_q  <= key_q;
      cand_lane_q <= winner_q;
    end else if (cmd_i.replay) begin
      cand_key_q  <= rep_key;
      cand_lane_q <= rep_lane;
    end
    if (cmd_i.seed_cmp && parent == ROOT) begin
      root_key_q  <= seed_key;
      root_lane_q <= seed_lane;
    end else if (cmd_i.replay && parent == ROOT) begin
      root_key_q  <= rep_key;
      root_lane_q <= rep_lane;
    end
    if (cmd_i.emit) begin
      out_done_q <= dead_q[ROOT];
      out_key_q  <= dead_q[ROOT] ? '0 : root_key_q;
      out_row_q  <= dead_q[ROOT] ? '0 : row_rd_q;
      out_lane_q <= dead_q[ROOT] ? '0 : LANE_W'(root_lane_q);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_q      <= '1;
      idx_q       <= '0;
      cand_dead_q <= 1'b1;
      winner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_leaf && load_ok) begin
        dead_q[load_node] <= exh_q;
      end
      if (cmd_i.kill) begin
        for (int i = 0; i < WAYS; i++) begin
          if (i >= int'(lanes_in_use_i)) begin
            dead_q[WAYS + i] <= 1'b1;
          end
        end
        idx_q <= LAST_NODE;
      end
      if (cmd_i.seed_cmp) begin
        dead_q[parent] <= seed_dead;
        idx_q          <= idx_q - TWO;
      end
      if (cmd_i.refill_leaf) begin
        dead_q[win_node] <= exh_q;
        cand_dead_q      <= exh_q;
        idx_q            <= win_node;
      end
      if (cmd_i.replay) begin
        dead_q[parent] <= rep_dead;
        cand_dead_q    <= rep_dead;
        idx_q          <= parent;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (!dead_q[ROOT]) begin
          winner_q <= root_lane_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.root_dead   = dead_q[ROOT];
  assign sts_o.seed_last   = (idx_q == SEED_END);
  assign sts_o.replay_last = (parent == ROOT);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_row_o   = out_row_q;
  assign out_lane_o  = out_lane_q;
  assign out_done_o  = out_done_q;

endmodule

FILE: rtl/k_way_merge_tournament.sv
`timescale 1ns / 1ps
// k_way_merge_tournament: top level of the k-way merge tournament tree.
// Depends on kwmt_pkg, kwmt_ctrl and kwmt_dpath.
//
//  channel  | dir | handshake                     | contents
//  ---------+-----+-------------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | load, start or refill transaction
//  m_axis   | out | m_axis_tvalid / m_axis_tready | emitted element or done marker
//  cfg      | in  | cfg_valid_i / cfg_ready_o     | lanes_in_use register write
//
// Seeding visits every sibling pair twice (read, then compare and write) through the
// node memory; a refill replays one level per cycle, the sibling read being registered
// ahead of its compare while the running winner stays in a register.
// Reset clears all tree nodes to exhausted, the winner lane to 0, lanes_in_use to 16.
// The result sits in an output register, so a new transaction is taken while it waits;
// a later result holds the engine until that register frees up.
module k_way_merge_tournament import kwmt_pkg::*; #(
  parameter int WAYS = WAYS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: lane[3:0], key[67:4], row[130:68], exhausted[131], zero pad[135:132]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action[1:0]
  input  logic [ACT_W-1:0]      s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: out_key[63:0], out_row[126:64], out_lane[130:127], zero pad[135:131]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: done_res[0]
  output logic [0:0]            m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [LIM_W-1:0]      cfg_data_i
);

  localparam int OUT_PAD = OUT_DATA_W - KEY_W - ROW_W - LANE_W;

  localparam int LANE_LO = 0;
  localparam int KEY_LO  = LANE_LO + LANE_W;
  localparam int ROW_LO  = KEY_LO + KEY_W;
  localparam int EXH_LO  = ROW_LO + ROW_W;

  logic [LIM_W-1:0]  lanes_in_use_q;
  cmd_t              cmd;
  sts_t              sts;
  logic [KEY_W-1:0]  out_key;
  logic [ROW_W-1:0]  out_row;
  logic [LANE_W-1:0] out_lane;
  logic              out_done;

  // configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_in_use_q <= LIM_RESET;
    end else if (cfg_valid_i) begin
      lanes_in_use_q <= cfg_data_i;
    end
  end

  kwmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kwmt_dpath #(
    .WAYS (WAYS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .lanes_in_use_i (lanes_in_use_q),
    .in_lane_i      (s_axis_tdata[LANE_LO +: LANE_W]),
    .in_key_i       (s_axis_tdata[KEY_LO +: KEY_W]),
    .in_row_i       (s_axis_tdata[ROW_LO +: ROW_W]),
    .in_exh_i       (s_axis_tdata[EXH_LO]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_key_o      (out_key),
    .out_row_o      (out_row),
    .out_lane_o     (out_lane),
    .out_done_o     (out_done)
  );

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, out_lane, out_row, out_key};
  assign m_axis_tuser = out_done;

endmodule
